FILE: rtl/core/assert_macros.svh
// Assertion helpers, clocked on aclk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define EFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define EFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/efs_pkg.sv
package efs_pkg;

    localparam int FEE_WIDTH = 64;
    localparam int DW        = 64;
    localparam int CW        = $clog2(DW);

    localparam logic [DW-1:0] FEE_MAX = DW'((65'd1 << FEE_WIDTH) - 65'd1);

    // configuration register indexes
    localparam logic [1:0] REG_LOAD_BASE = 2'd0;
    localparam logic [1:0] REG_BASE_FEE  = 2'd1;
    localparam logic [1:0] REG_FEE_UNITS = 2'd2;

    // shared unit operations
    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic [63:0] fee_in;
        logic [31:0] local_factor;
        logic [31:0] remote_factor;
        logic        privileged;
    } fee_req_t;

    typedef struct packed {
        logic [63:0] scaled_fee;
        logic        overflow;
    } fee_rsp_t;

endpackage

FILE: rtl/core/exact_fee_scale_muldiv.sv
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_valid / s_ready  | efs_pkg::fee_req_t (fee, factors, privileged)
// m_      | out | m_valid / m_ready  | efs_pkg::fee_rsp_t (scaled fee, overflow)
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index (2b), cfg_data (64b)
//
// Math: one shared 64-step shift-add / restoring-divide unit does all the
//   math, one operation at a time. A request runs the denominator product,
//   the Euclid steps of the three gcd reductions and the scaling operations;
//   a zero fee skips the unit, and a zero denominator ends the request
//   after the denominator product, with overflow set.
// Reset: aresetn synchronous, low active; registers return to 256 / 10 / 10.
// Stalls: s_ready is high only when idle; a finished result waits in the
//   output register, and the next one waits for m_ready before loading it.
`include "assert_macros.svh"

module exact_fee_scale_muldiv (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  efs_pkg::fee_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output efs_pkg::fee_rsp_t  m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int DW = efs_pkg::DW;
    localparam int CW = efs_pkg::CW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEN   = 4'd1;   // den = fee_units * load_base
    localparam logic [3:0] S_GCD   = 4'd2;   // Euclid step decision
    localparam logic [3:0] S_GCDW  = 4'd3;   // a mod b running
    localparam logic [3:0] S_RNUM  = 4'd4;   // num / g
    localparam logic [3:0] S_RDEN  = 4'd5;   // den / g
    localparam logic [3:0] S_CHK   = 4'd6;   // order, zero check
    localparam logic [3:0] S_LIM   = 4'd7;   // max / loc
    localparam logic [3:0] S_BMUL  = 4'd8;   // base * loc
    localparam logic [3:0] S_FLIM  = 4'd9;   // max / base
    localparam logic [3:0] S_FDIV1 = 4'd10;  // divide first
    localparam logic [3:0] S_FMUL1 = 4'd11;
    localparam logic [3:0] S_FMUL2 = 4'd12;  // multiply first
    localparam logic [3:0] S_FDIV2 = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]    state_reg;

    // configuration
    logic [31:0]   load_base_reg;
    logic [63:0]   base_fee_reg;
    logic [31:0]   fee_units_reg;

    // working operands
    logic [DW-1:0] fee_reg, base_reg, den_reg, lim_reg, ga_reg, gb_reg;
    logic [31:0]   loc_reg;
    logic [1:0]    idx_reg;              // 0 fee, 1 base, 2 factor
    logic [DW-1:0] res_reg;
    logic          ovf_reg;

    // shared unit
    logic          eop_reg;
    logic          ebusy_reg;
    logic [CW-1:0] ecnt_reg;
    logic [DW-1:0] ea_reg;               // multiplicand / dividend -> quotient
    logic [DW-1:0] eb_reg;               // multiplier / divisor
    logic [DW-1:0] eacc_reg;             // product / remainder

    logic          m_valid_reg;
    efs_pkg::fee_rsp_t m_data_reg;

    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_sub;
    logic [33:0]   rem_x4;
    logic [31:0]   loc_in;
    logic [DW-1:0] num_sel, next_num;
    logic          chk_swap;
    logic [DW-1:0] chk_fee, chk_base;
    logic [DW-1:0] bm_hi, bm_lo;

    assign rem_shift = {eacc_reg, ea_reg[DW-1]};
    assign rem_sub   = rem_shift - {1'b0, eb_reg};

    // privileged relief, compare against 4 * remote without wrap
    assign rem_x4 = {s_data.remote_factor, 2'b00};
    always_comb begin
        loc_in = s_data.local_factor;
        if (s_data.privileged && (s_data.local_factor > s_data.remote_factor)
                && ({2'b00, s_data.local_factor} < rem_x4)) begin
            loc_in = s_data.remote_factor;
        end
    end

    always_comb begin
        case (idx_reg)
            2'd0:    num_sel = fee_reg;
            2'd1:    num_sel = base_reg;
            default: num_sel = DW'(loc_reg);
        endcase
        case (idx_reg)
            2'd0:    next_num = base_reg;
            default: next_num = DW'(loc_reg);
        endcase
    end

    assign chk_swap = fee_reg < base_reg;
    assign chk_fee  = chk_swap ? base_reg : fee_reg;
    assign chk_base = chk_swap ? fee_reg  : base_reg;
    assign bm_hi    = (fee_reg < eacc_reg) ? eacc_reg : fee_reg;
    assign bm_lo    = (fee_reg < eacc_reg) ? fee_reg  : eacc_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ebusy_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            load_base_reg <= 32'd256;
            base_fee_reg  <= 64'd10;
            fee_units_reg <= 32'd10;
        end else begin
            // shared unit step
            if (ebusy_reg) begin
                if (eop_reg == efs_pkg::OP_MUL) begin
                    if (eb_reg[0]) begin
                        eacc_reg <= eacc_reg + ea_reg;
                    end
                    ea_reg <= {ea_reg[DW-2:0], 1'b0};
                    eb_reg <= {1'b0, eb_reg[DW-1:1]};
                end else begin
                    if (!rem_sub[DW]) begin
                        eacc_reg <= rem_sub[DW-1:0];
                        ea_reg   <= {ea_reg[DW-2:0], 1'b1};
                    end else begin
                        eacc_reg <= rem_shift[DW-1:0];
                        ea_reg   <= {ea_reg[DW-2:0], 1'b0};
                    end
                end
                ecnt_reg <= ecnt_reg - CW'(1);
                if (ecnt_reg == '0) begin
                    ebusy_reg <= 1'b0;
                end
            end

            // S_OUT reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        fee_reg  <= s_data.fee_in & efs_pkg::FEE_MAX;
                        base_reg <= base_fee_reg & efs_pkg::FEE_MAX;
                        loc_reg  <= loc_in;
                        idx_reg  <= 2'd0;
                        res_reg  <= '0;
                        ovf_reg  <= 1'b0;
                        if ((s_data.fee_in & efs_pkg::FEE_MAX) == '0) begin
                            state_reg <= S_OUT;
                        end else begin
                            eop_reg   <= efs_pkg::OP_MUL;
                            ea_reg    <= DW'(fee_units_reg);
                            eb_reg    <= DW'(load_base_reg);
                            eacc_reg  <= '0;
                            ecnt_reg  <= CW'(DW - 1);
                            ebusy_reg <= 1'b1;
                            state_reg <= S_DEN;
                        end
                    end
                end
                S_DEN: begin
                    if (!ebusy_reg) begin
                        den_reg <= eacc_reg;
                        ga_reg  <= fee_reg;
                        gb_reg  <= eacc_reg;
                        if (eacc_reg == '0) begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    eop_reg   <= efs_pkg::OP_DIV;
                    eacc_reg  <= '0;
                    ecnt_reg  <= CW'(DW - 1);
                    ebusy_reg <= 1'b1;
                    if (gb_reg == '0) begin
                        // gcd found in ga_reg, never zero since den is nonzero
                        ea_reg    <= num_sel;
                        eb_reg    <= ga_reg;
                        state_reg <= S_RNUM;
                    end else begin
                        ea_reg    <= ga_reg;
                        eb_reg    <= gb_reg;
                        state_reg <= S_GCDW;
                    end
                end
                S_GCDW: begin
                    if (!ebusy_reg) begin
                        ga_reg    <= gb_reg;
                        gb_reg    <= eacc_reg;
                        state_reg <= S_GCD;
                    end
                end
                S_RNUM: begin
                    if (!ebusy_reg) begin
                        case (idx_reg)
                            2'd0:    fee_reg  <= ea_reg;
                            2'd1:    base_reg <= ea_reg;
                            default: loc_reg  <= ea_reg[31:0];
                        endcase
                        ea_reg    <= den_reg;
                        eb_reg    <= ga_reg;
                        eacc_reg  <= '0;
                        ecnt_reg  <= CW'(DW - 1);
                        ebusy_reg <= 1'b1;
                        state_reg <= S_RDEN;
                    end
                end
                S_RDEN: begin
                    if (!ebusy_reg) begin
                        den_reg <= ea_reg;
                        if (idx_reg == 2'd2) begin
                            state_reg <= S_CHK;
                        end else begin
                            idx_reg   <= idx_reg + 2'd1;
                            ga_reg    <= next_num;
                            gb_reg    <= ea_reg;
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_CHK: begin
                    fee_reg  <= chk_fee;
                    base_reg <= chk_base;
                    if (loc_reg == '0 || chk_base == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        eop_reg   <= efs_pkg::OP_DIV;
                        ea_reg    <= efs_pkg::FEE_MAX;
                        eb_reg    <= DW'(loc_reg);
                        eacc_reg  <= '0;
                        ecnt_reg  <= CW'(DW - 1);
                        ebusy_reg <= 1'b1;
                        state_reg <= S_LIM;
                    end
                end
                S_LIM: begin
                    if (!ebusy_reg) begin
                        if (base_reg > ea_reg) begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            eop_reg   <= efs_pkg::OP_MUL;
                            ea_reg    <= base_reg;
                            eb_reg    <= DW'(loc_reg);
                            eacc_reg  <= '0;
                            ecnt_reg  <= CW'(DW - 1);
                            ebusy_reg <= 1'b1;
                            state_reg <= S_BMUL;
                        end
                    end
                end
                S_BMUL: begin
                    if (!ebusy_reg) begin
                        fee_reg   <= bm_hi;
                        base_reg  <= bm_lo;
                        eop_reg   <= efs_pkg::OP_DIV;
                        ea_reg    <= efs_pkg::FEE_MAX;
                        eb_reg    <= bm_lo;
                        eacc_reg  <= '0;
                        ecnt_reg  <= CW'(DW - 1);
                        ebusy_reg <= 1'b1;
                        state_reg <= S_FLIM;
                    end
                end
                S_FLIM: begin
                    if (!ebusy_reg) begin
                        lim_reg   <= ea_reg;
                        eacc_reg  <= '0;
                        ecnt_reg  <= CW'(DW - 1);
                        ebusy_reg <= 1'b1;
                        if (fee_reg > ea_reg) begin
                            eop_reg   <= efs_pkg::OP_DIV;
                            ea_reg    <= fee_reg;
                            eb_reg    <= den_reg;
                            state_reg <= S_FDIV1;
                        end else begin
                            eop_reg   <= efs_pkg::OP_MUL;
                            ea_reg    <= fee_reg;
                            eb_reg    <= base_reg;
                            state_reg <= S_FMUL2;
                        end
                    end
                end
                S_FDIV1: begin
                    if (!ebusy_reg) begin
                        if (ea_reg > lim_reg) begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            eop_reg   <= efs_pkg::OP_MUL;
                            eb_reg    <= base_reg;
                            eacc_reg  <= '0;
                            ecnt_reg  <= CW'(DW - 1);
                            ebusy_reg <= 1'b1;
                            state_reg <= S_FMUL1;
                        end
                    end
                end
                S_FMUL1: begin
                    if (!ebusy_reg) begin
                        res_reg   <= eacc_reg & efs_pkg::FEE_MAX;
                        state_reg <= S_OUT;
                    end
                end
                S_FMUL2: begin
                    if (!ebusy_reg) begin
                        eop_reg   <= efs_pkg::OP_DIV;
                        ea_reg    <= eacc_reg;
                        eb_reg    <= den_reg;
                        eacc_reg  <= '0;
                        ecnt_reg  <= CW'(DW - 1);
                        ebusy_reg <= 1'b1;
                        state_reg <= S_FDIV2;
                    end
                end
                S_FDIV2: begin
                    if (!ebusy_reg) begin
                        res_reg   <= ea_reg & efs_pkg::FEE_MAX;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.scaled_fee <= ovf_reg ? '0 : res_reg;
                        m_data_reg.overflow   <= ovf_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_valid) begin
                unique case (cfg_index)
                    efs_pkg::REG_LOAD_BASE: load_base_reg <= cfg_data[31:0];
                    efs_pkg::REG_BASE_FEE:  base_fee_reg  <= cfg_data;
                    efs_pkg::REG_FEE_UNITS: fee_units_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    // shared unit is never left running while a new request may enter
    `EFS_ASSERT_IMP(a_idle_unit_free, s_ready, !ebusy_reg)
    // overflow results carry a zero fee
    `EFS_ASSERT_IMP(a_ovf_zero, m_valid && m_data.overflow, m_data.scaled_fee == '0)
    // an accepted request closes the input until it is done
    `EFS_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

endmodule
